// ===== sv/hidri_pkg.sv =====
// ----------------------------------------------------------------------------
// hidri_pkg
// Shared types and constants for the HID report descriptor item interpreter.
// ----------------------------------------------------------------------------
package hidri_pkg;

    localparam int MaxUsages  = 16;
    localparam int StackDepth = 4;
    localparam int MaxRun     = 64;

    localparam int UsageIdxW = $clog2(MaxUsages);
    localparam int UsageCntW = $clog2(MaxUsages + 1);
    localparam int LevelW    = $clog2(StackDepth + 1);

    localparam logic [1:0] OP_MAIN   = 2'd0;
    localparam logic [1:0] OP_GLOBAL = 2'd1;
    localparam logic [1:0] OP_LOCAL  = 2'd2;

    localparam logic [3:0] TAG_INPUT    = 4'd8;
    localparam logic [3:0] TAG_OUTPUT   = 4'd9;
    localparam logic [3:0] TAG_COLL     = 4'd10;
    localparam logic [3:0] TAG_FEATURE  = 4'd11;
    localparam logic [3:0] TAG_END_COLL = 4'd12;

    localparam logic [3:0] TAG_PAGE  = 4'd0;
    localparam logic [3:0] TAG_SIZE  = 4'd7;
    localparam logic [3:0] TAG_ID    = 4'd8;
    localparam logic [3:0] TAG_COUNT = 4'd9;
    localparam logic [3:0] TAG_PUSH  = 4'd10;
    localparam logic [3:0] TAG_POP   = 4'd11;

    localparam logic [3:0] TAG_USAGE = 4'd0;
    localparam logic [3:0] TAG_UMIN  = 4'd1;
    localparam logic [3:0] TAG_UMAX  = 4'd2;

    localparam logic [1:0] EV_FIELD = 2'd0;
    localparam logic [1:0] EV_OPEN  = 2'd1;
    localparam logic [1:0] EV_CLOSE = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
    localparam logic [2:0] ERR_LIST_FULL = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    localparam logic [1:0] RK_INPUT   = 2'd0;
    localparam logic [1:0] RK_OUTPUT  = 2'd1;
    localparam logic [1:0] RK_FEATURE = 2'd2;

    typedef struct packed {
        logic [15:0] page;
        logic [7:0]  id;
        logic [15:0] size;
        logic [15:0] count;
    } globals_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_EVENT = 2'd1,
        ACT_RUN   = 2'd2
    } action_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture accepted transaction
        logic decode;    // apply item, compute action
        logic run_start; // prepare a field run
        logic run_step;  // advance one record
        logic fetch;     // issue usage list read
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        action_t action;
        logic    run_empty;
        logic    run_final;
    } dp_status_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  report_id;
        logic [15:0] start_bit;
        logic [15:0] bit_size;
        logic [31:0] usage_value;
        logic [15:0] field_count;
        logic [1:0]  report_kind;
        logic [7:0]  collection_type;
        logic [2:0]  error_code;
    } result_t;

endpackage

// ===== sv/hidri_datapath.sv =====
// ----------------------------------------------------------------------------
// hidri_datapath
// Parser state, global stack, usage list memory and field run generation.
// ----------------------------------------------------------------------------
module hidri_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hidri_pkg::dp_cmd_t   cmd,
    output hidri_pkg::dp_status_t status,
    input  logic [1:0]           in_opcode,
    input  logic [3:0]           in_item_tag,
    input  logic [2:0]           in_data_size,
    input  logic [31:0]          in_item_data,
    output hidri_pkg::result_t   result
);

    logic [1:0]  opcode_reg;
    logic [3:0]  tag_reg;
    logic [2:0]  nb_reg;
    logic [31:0] data_reg;

    hidri_pkg::globals_t gstack_reg [hidri_pkg::StackDepth + 1];
    logic [hidri_pkg::LevelW-1:0]    level_reg;
    logic [hidri_pkg::UsageCntW-1:0] ucount_reg;
    logic                            range_reg;
    logic [31:0]                     ulow_reg;
    logic [31:0]                     uhigh_reg;
    logic [15:0]                     cursor_reg;

    logic [31:0] umem [hidri_pkg::MaxUsages];
    logic [31:0] umem_q;

    hidri_pkg::action_t action_reg;
    hidri_pkg::result_t res_reg;

    // run state
    logic [16:0] run_n_reg;
    logic [6:0]  run_emit_reg;
    logic [6:0]  run_i_reg;
    logic        run_pad_reg;
    logic        run_rng_reg;
    logic        run_trunc_reg;
    logic [15:0] run_fcount_reg;
    logic [15:0] run_start_reg;
    logic [31:0] run_prod_reg;
    logic [1:0]  run_rk_reg;

    hidri_pkg::globals_t g;
    logic [31:0] mask;
    logic [31:0] d;
    logic [31:0] composed;
    logic [2:0]  nb;

    always_comb begin
        nb = (nb_reg > 3'd4) ? 3'd4 : nb_reg;
        unique case (nb)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        d = data_reg & mask;
        g = gstack_reg[level_reg];
        composed = ({g.page, 16'h0000} & ~mask) | d;
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            opcode_reg <= in_opcode;
            tag_reg    <= in_item_tag;
            nb_reg     <= in_data_size;
            data_reg   <= in_item_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            umem_q <= umem[run_i_reg[hidri_pkg::UsageIdxW-1:0]];
        end
        if (cmd.decode && opcode_reg == hidri_pkg::OP_LOCAL && tag_reg == hidri_pkg::TAG_USAGE
            && (range_reg || ucount_reg < hidri_pkg::UsageCntW'(hidri_pkg::MaxUsages))) begin
            umem[range_reg ? '0 : ucount_reg[hidri_pkg::UsageIdxW-1:0]] <= composed;
        end
    end

    logic is_run;
    logic [1:0] rk;
    always_comb begin
        is_run = 1'b0;
        rk = hidri_pkg::RK_INPUT;
        if (opcode_reg == hidri_pkg::OP_MAIN) begin
            priority case (tag_reg)
                hidri_pkg::TAG_INPUT:   begin is_run = 1'b1; rk = hidri_pkg::RK_INPUT;   end
                hidri_pkg::TAG_OUTPUT:  begin is_run = 1'b1; rk = hidri_pkg::RK_OUTPUT;  end
                hidri_pkg::TAG_FEATURE: begin is_run = 1'b1; rk = hidri_pkg::RK_FEATURE; end
                default: ;
            endcase
        end
    end

    logic [16:0] n_sel;
    always_comb begin
        if (range_reg || ucount_reg == '0) n_sel = {1'b0, g.count};
        else n_sel = 17'(ucount_reg);
    end

    always_ff @(posedge aclk) begin
        hidri_pkg::result_t res_v;
        hidri_pkg::action_t act_v;
        if (!aresetn) begin
            level_reg  <= '0;
            ucount_reg <= '0;
            range_reg  <= 1'b0;
            ulow_reg   <= '0;
            uhigh_reg  <= '0;
            cursor_reg <= '0;
            gstack_reg[0] <= '0;
            action_reg <= hidri_pkg::ACT_NONE;
        end else if (cmd.decode) begin
            act_v = hidri_pkg::ACT_NONE;
            res_v = '0;
            unique case (opcode_reg)
                hidri_pkg::OP_MAIN: begin
                    if (is_run) begin
                        act_v          = hidri_pkg::ACT_RUN;
                        run_rk_reg     <= rk;
                        run_n_reg      <= n_sel;
                        run_rng_reg    <= range_reg;
                        run_pad_reg    <= !range_reg && ucount_reg == '0;
                        run_fcount_reg <= (!range_reg && ucount_reg == 1) ? g.count : 16'd1;
                        run_start_reg  <= cursor_reg;
                    end else if (tag_reg == hidri_pkg::TAG_COLL) begin
                        act_v = hidri_pkg::ACT_EVENT;
                        res_v.event_kind      = hidri_pkg::EV_OPEN;
                        res_v.usage_value     = range_reg ? ulow_reg
                                              : (ucount_reg != '0 ? umem[0] : 32'd0);
                        res_v.collection_type = d[7:0];
                    end else if (tag_reg == hidri_pkg::TAG_END_COLL) begin
                        act_v = hidri_pkg::ACT_EVENT;
                        res_v.event_kind = hidri_pkg::EV_CLOSE;
                    end
                    ucount_reg <= '0;
                    range_reg  <= 1'b0;
                end
                hidri_pkg::OP_GLOBAL: begin
                    priority case (tag_reg)
                        hidri_pkg::TAG_PAGE:  gstack_reg[level_reg].page  <= d[15:0];
                        hidri_pkg::TAG_SIZE:  gstack_reg[level_reg].size  <= d[15:0];
                        hidri_pkg::TAG_COUNT: gstack_reg[level_reg].count <= d[15:0];
                        hidri_pkg::TAG_ID: begin
                            gstack_reg[level_reg].id <= d[7:0];
                            cursor_reg <= '0;
                            ucount_reg <= '0;
                            range_reg  <= 1'b0;
                        end
                        hidri_pkg::TAG_PUSH: begin
                            if (level_reg < hidri_pkg::LevelW'(hidri_pkg::StackDepth)) begin
                                gstack_reg[level_reg + 1'b1] <= g;
                                level_reg <= level_reg + 1'b1;
                            end else begin
                                act_v = hidri_pkg::ACT_EVENT;
                                res_v.event_kind = hidri_pkg::EV_ERROR;
                                res_v.error_code = hidri_pkg::ERR_OVERFLOW;
                            end
                        end
                        hidri_pkg::TAG_POP: begin
                            if (level_reg != '0) begin
                                level_reg <= level_reg - 1'b1;
                            end else begin
                                act_v = hidri_pkg::ACT_EVENT;
                                res_v.event_kind = hidri_pkg::EV_ERROR;
                                res_v.error_code = hidri_pkg::ERR_UNDERFLOW;
                            end
                        end
                        default: ;
                    endcase
                end
                hidri_pkg::OP_LOCAL: begin
                    priority case (tag_reg)
                        hidri_pkg::TAG_USAGE: begin
                            if (range_reg) begin
                                range_reg  <= 1'b0;
                                ucount_reg <= hidri_pkg::UsageCntW'(1);
                            end else if (ucount_reg
                                         >= hidri_pkg::UsageCntW'(hidri_pkg::MaxUsages)) begin
                                act_v = hidri_pkg::ACT_EVENT;
                                res_v.event_kind = hidri_pkg::EV_ERROR;
                                res_v.error_code = hidri_pkg::ERR_LIST_FULL;
                            end else begin
                                ucount_reg <= ucount_reg + 1'b1;
                            end
                        end
                        hidri_pkg::TAG_UMIN: begin
                            ulow_reg <= composed; range_reg <= 1'b1; ucount_reg <= '0;
                        end
                        hidri_pkg::TAG_UMAX: begin
                            uhigh_reg <= composed; range_reg <= 1'b1; ucount_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            action_reg <= act_v;
            res_reg    <= res_v;
        end else if (cmd.run_start) begin
            run_trunc_reg <= run_n_reg > 17'(hidri_pkg::MaxRun);
            run_emit_reg  <= (run_n_reg > 17'(hidri_pkg::MaxRun))
                             ? 7'(hidri_pkg::MaxRun - 1) : run_n_reg[6:0];
            run_i_reg     <= '0;
            run_prod_reg  <= 32'(run_n_reg) * 32'(g.size);
        end else if (cmd.run_step) begin
            res_v = '0;
            if (run_i_reg == run_emit_reg) begin
                res_v.event_kind = hidri_pkg::EV_ERROR;
                res_v.error_code = hidri_pkg::ERR_TRUNCATED;
            end else begin
                res_v.event_kind  = hidri_pkg::EV_FIELD;
                res_v.report_id   = g.id;
                res_v.start_bit   = run_start_reg;
                res_v.bit_size    = g.size;
                res_v.usage_value = run_rng_reg ? ulow_reg + 32'(run_i_reg)
                                  : (run_pad_reg ? 32'd0 : umem_q);
                res_v.field_count = run_fcount_reg;
                res_v.report_kind = run_rk_reg;
                res_v.error_code  = hidri_pkg::ERR_NONE;
                run_start_reg <= run_start_reg + g.size;
            end
            res_reg   <= res_v;
            run_i_reg <= run_i_reg + 1'b1;
            if (run_i_reg + 1'b1 >= run_emit_reg + 7'(run_trunc_reg)) begin
                cursor_reg <= cursor_reg + run_prod_reg[15:0];
            end
        end
    end

    always_comb begin
        status.action    = action_reg;
        status.run_empty = (run_emit_reg == '0) && !run_trunc_reg;
        status.run_final = (run_i_reg + 1'b1 >= run_emit_reg + 7'(run_trunc_reg));
        result           = res_reg;
    end

    logic unused_uhigh;
    assign unused_uhigh = ^uhigh_reg;

endmodule

// ===== sv/hidri_controller.sv =====
// ----------------------------------------------------------------------------
// hidri_controller
// Sequencer: decode, run emission and output handshake.
// ----------------------------------------------------------------------------
module hidri_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_last,
    output hidri_pkg::dp_cmd_t    cmd,
    input  hidri_pkg::dp_status_t status
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_ACT    = 6'b000100,
        ST_FETCH  = 6'b001000,
        ST_STEP   = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   in_run_reg, in_run_next;

    always_comb begin
        state_next  = state_reg;
        last_next   = last_reg;
        in_run_next = in_run_reg;
        cmd         = '0;
        s_ready     = (state_reg == ST_IDLE);
        m_valid     = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE: begin
                cmd.latch = s_valid;
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = ST_ACT;
            end
            ST_ACT: begin
                unique case (status.action)
                    hidri_pkg::ACT_EVENT: begin
                        last_next = 1'b1; in_run_next = 1'b0; state_next = ST_OUT;
                    end
                    hidri_pkg::ACT_RUN: begin
                        cmd.run_start = 1'b1; in_run_next = 1'b1; state_next = ST_FETCH;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_FETCH: begin
                if (status.run_empty) begin
                    cmd.run_step = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.fetch = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.run_step = 1'b1;
                last_next  = status.run_final;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = (in_run_reg && !last_reg) ? ST_FETCH : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            last_reg   <= 1'b0;
            in_run_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            in_run_reg <= in_run_next;
        end
    end

    assign m_last = last_reg;

endmodule

// ===== sv/hid_report_descriptor_item_interpreter_top.sv =====
// ----------------------------------------------------------------------------
// hid_report_descriptor_item_interpreter_top
// HID report descriptor item interpreter.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    opcode, item_tag, data_size, item_data
//   m_       out        m_valid/m_ready    event record, m_last
//
// An item with no result passes through the idle, decode and act states; a single
// event also waits in the output state until the receiver takes it.
// A field run is set up in idle, decode and act, then each record takes the usage
// memory read, build and present steps in turn.
// Reset clears all control state and global stack entry zero.
// Input is held off while an item is in progress; output stalls hold the record.
// ----------------------------------------------------------------------------
module hid_report_descriptor_item_interpreter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [3:0]  s_item_tag,
    input  logic [2:0]  s_data_size,
    input  logic [31:0] s_item_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [7:0]  m_report_id,
    output logic [15:0] m_start_bit,
    output logic [15:0] m_bit_size,
    output logic [31:0] m_usage_value,
    output logic [15:0] m_field_count,
    output logic [1:0]  m_report_kind,
    output logic [7:0]  m_collection_type,
    output logic [2:0]  m_error_code,
    output logic        m_last
);

    hidri_pkg::dp_cmd_t    cmd;
    hidri_pkg::dp_status_t status;
    hidri_pkg::result_t    result;

    hidri_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last),
        .cmd     (cmd),
        .status  (status)
    );

    hidri_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .in_opcode    (s_opcode),
        .in_item_tag  (s_item_tag),
        .in_data_size (s_data_size),
        .in_item_data (s_item_data),
        .result       (result)
    );

    assign m_event_kind      = result.event_kind;
    assign m_report_id       = result.report_id;
    assign m_start_bit       = result.start_bit;
    assign m_bit_size        = result.bit_size;
    assign m_usage_value     = result.usage_value;
    assign m_field_count     = result.field_count;
    assign m_report_kind     = result.report_kind;
    assign m_collection_type = result.collection_type;
    assign m_error_code      = result.error_code;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while result pending");

    a_error_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind != hidri_pkg::EV_ERROR)
            |-> m_error_code == hidri_pkg::ERR_NONE)
        else $error("error code on non-error event");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_usage_value)))
        else $error("result changed under stall");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the HID report descriptor item interpreter. Directed item
// sequences cover the globals, the push/pop stack, usage lists, usage ranges,
// padding, collections and the error notices. Random descriptor fragments
// follow under several sender/receiver idling mixes. A behavioral predictor
// queues the expected events and a checker compares every output transaction.
// ----------------------------------------------------------------------------
module tb_top;
    import hidri_pkg::*;

    typedef struct {
        result_t r;
        bit      last;
    } hid_event_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [3:0]  s_item_tag;
    logic [2:0]  s_data_size;
    logic [31:0] s_item_data;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_event_kind;
    logic [7:0]  m_report_id;
    logic [15:0] m_start_bit;
    logic [15:0] m_bit_size;
    logic [31:0] m_usage_value;
    logic [15:0] m_field_count;
    logic [1:0]  m_report_kind;
    logic [7:0]  m_collection_type;
    logic [2:0]  m_error_code;
    logic        m_last;

    hid_report_descriptor_item_interpreter_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_item_tag       (s_item_tag),
        .s_data_size      (s_data_size),
        .s_item_data      (s_item_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_report_id      (m_report_id),
        .m_start_bit      (m_start_bit),
        .m_bit_size       (m_bit_size),
        .m_usage_value    (m_usage_value),
        .m_field_count    (m_field_count),
        .m_report_kind    (m_report_kind),
        .m_collection_type(m_collection_type),
        .m_error_code     (m_error_code),
        .m_last           (m_last)
    );

    // predictor state
    globals_t    gstack[0:StackDepth];
    int unsigned level;
    logic [31:0] usages[MaxUsages];
    int unsigned usage_cnt;
    bit          range_on;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [15:0] cursor;

    hid_event_t  event_q[$];
    int          err_count;
    int          sender_idle_pct;
    int          receiver_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(8 * 1500000);
        $display("CHECK FAILED");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge aclk) begin
        hid_event_t e;
        if (aresetn && m_valid && m_ready) begin
            if (event_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_event_kind, 0);
            end else begin
                e = event_q.pop_front();
                check_field("event_kind", m_event_kind, e.r.event_kind);
                check_field("report_id", m_report_id, e.r.report_id);
                check_field("start_bit", m_start_bit, e.r.start_bit);
                check_field("bit_size", m_bit_size, e.r.bit_size);
                check_field("usage_value", m_usage_value, e.r.usage_value);
                check_field("field_count", m_field_count, e.r.field_count);
                check_field("report_kind", m_report_kind, e.r.report_kind);
                check_field("collection_type", m_collection_type, e.r.collection_type);
                check_field("error_code", m_error_code, e.r.error_code);
                check_field("last", m_last, e.last);
            end
        end
    end

    function automatic void queue_event(input logic [1:0] kind, input logic [7:0] id,
                                        input logic [15:0] start, input logic [15:0] size,
                                        input logic [31:0] usage, input logic [15:0] cnt,
                                        input logic [1:0] rk, input logic [7:0] ctype,
                                        input logic [2:0] err);
        hid_event_t e;
        e.r = '{kind, id, start, size, usage, cnt, rk, ctype, err};
        e.last = 1'b0;
        event_q.push_back(e);
    endfunction

    function automatic void queue_field_run(input logic [1:0] rk);
        globals_t    g;
        int unsigned n;
        int unsigned emitted;
        logic [15:0] fcount;
        logic [31:0] u;
        bit          pad;
        g = gstack[level];
        pad = 1'b0;
        if (range_on) begin
            n = g.count;
            fcount = 16'd1;
        end else if (usage_cnt == 0) begin
            n = g.count;
            fcount = 16'd1;
            pad = 1'b1;
        end else begin
            n = usage_cnt;
            fcount = (usage_cnt == 1) ? g.count : 16'd1;
        end
        emitted = (n > MaxRun) ? MaxRun - 1 : n;
        for (int unsigned i = 0; i < emitted; i++) begin
            if (range_on) u = range_low + i;
            else if (pad) u = '0;
            else u = usages[i % MaxUsages];
            queue_event(EV_FIELD, g.id, cursor + 16'(i * g.size), g.size, u, fcount,
                        rk, 8'd0, ERR_NONE);
        end
        if (n > MaxRun) begin
            queue_event(EV_ERROR, 0, 0, 0, 0, 0, 0, 0, ERR_TRUNCATED);
        end
        cursor = cursor + 16'(n * g.size);
    endfunction

    function automatic void predict_item(input logic [1:0] op, input logic [3:0] tag,
                                         input logic [2:0] ds, input logic [31:0] data);
        int unsigned nb;
        int          before_cnt;
        logic [31:0] mask;
        logic [31:0] d;
        logic [31:0] composed;
        before_cnt = event_q.size();
        nb = (ds > 4) ? 4 : ds;
        mask = (nb == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nb)) - 32'd1);
        d = data & mask;
        composed = ({gstack[level].page, 16'h0} & ~mask) | d;
        if (op == OP_MAIN) begin
            case (tag)
                TAG_INPUT:   queue_field_run(RK_INPUT);
                TAG_OUTPUT:  queue_field_run(RK_OUTPUT);
                TAG_FEATURE: queue_field_run(RK_FEATURE);
                TAG_COLL: begin
                    queue_event(EV_OPEN, 0, 0, 0,
                                range_on ? range_low : (usage_cnt > 0 ? usages[0] : 32'd0),
                                0, 0, d[7:0], ERR_NONE);
                end
                TAG_END_COLL: queue_event(EV_CLOSE, 0, 0, 0, 0, 0, 0, 0, ERR_NONE);
                default: ;
            endcase
            usage_cnt = 0;
            range_on = 1'b0;
        end else if (op == OP_GLOBAL) begin
            case (tag)
                TAG_PAGE:  gstack[level].page = d[15:0];
                TAG_SIZE:  gstack[level].size = d[15:0];
                TAG_COUNT: gstack[level].count = d[15:0];
                TAG_ID: begin
                    gstack[level].id = d[7:0];
                    cursor = '0;
                    usage_cnt = 0;
                    range_on = 1'b0;
                end
                TAG_PUSH: begin
                    if (level < StackDepth) begin
                        gstack[level + 1] = gstack[level];
                        level++;
                    end else begin
                        queue_event(EV_ERROR, 0, 0, 0, 0, 0, 0, 0, ERR_OVERFLOW);
                    end
                end
                TAG_POP: begin
                    if (level > 0) level--;
                    else queue_event(EV_ERROR, 0, 0, 0, 0, 0, 0, 0, ERR_UNDERFLOW);
                end
                default: ;
            endcase
        end else if (op == OP_LOCAL) begin
            case (tag)
                TAG_USAGE: begin
                    if (range_on) begin
                        range_on = 1'b0;
                        usage_cnt = 0;
                    end
                    if (usage_cnt >= MaxUsages) begin
                        queue_event(EV_ERROR, 0, 0, 0, 0, 0, 0, 0, ERR_LIST_FULL);
                    end else begin
                        usages[usage_cnt] = composed;
                        usage_cnt++;
                    end
                end
                TAG_UMIN: begin
                    range_low = composed;
                    range_on = 1'b1;
                    usage_cnt = 0;
                end
                TAG_UMAX: begin
                    range_high = composed;
                    range_on = 1'b1;
                    usage_cnt = 0;
                end
                default: ;
            endcase
        end
        if (event_q.size() > before_cnt) begin
            event_q[event_q.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [3:0] tag,
                             input logic [2:0] ds, input logic [31:0] data);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_item_tag  <= tag;
        s_data_size <= ds;
        s_item_data <= data;
        do @(posedge aclk); while (!s_ready);
        predict_item(op, tag, ds, data);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (event_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_globals_and_fields();
        send_item(OP_GLOBAL, TAG_PAGE, 3'd2, 32'h0000_FFFF);
        send_item(OP_GLOBAL, TAG_SIZE, 3'd1, 32'hFFFF_FF08);
        send_item(OP_GLOBAL, TAG_COUNT, 3'd7, 32'hABCD_0003);
        send_item(OP_GLOBAL, TAG_ID, 3'd4, 32'hFFFF_FFFF);
        send_item(OP_LOCAL, TAG_USAGE, 3'd1, 32'h1234_5630);
        send_item(OP_LOCAL, TAG_USAGE, 3'd4, 32'hDEAD_BEEF);
        send_item(OP_MAIN, TAG_INPUT, 3'd1, 32'h02);
        send_item(OP_LOCAL, TAG_USAGE, 3'd0, 32'hFFFF_FFFF);
        send_item(OP_MAIN, TAG_OUTPUT, 3'd0, 32'h0);
        send_item(OP_LOCAL, TAG_UMIN, 3'd7, 32'hFFFF_FFFE);
        send_item(OP_LOCAL, TAG_UMAX, 3'd2, 32'h0000_0010);
        send_item(OP_MAIN, TAG_FEATURE, 3'd1, 32'h0);
        send_item(OP_MAIN, TAG_INPUT, 3'd1, 32'h03);
        send_item(OP_MAIN, 4'd0, 3'd1, 32'h0);
        send_item(OP_GLOBAL, TAG_COUNT, 3'd2, 32'h0000_0000);
        send_item(OP_MAIN, TAG_INPUT, 3'd0, 32'h0);
        send_item(OP_GLOBAL, 4'd1, 3'd1, 32'h55);
        send_item(OP_LOCAL, 4'd5, 3'd1, 32'h55);
        send_item(2'd3, 4'd15, 3'd4, 32'hFFFF_FFFF);
    endtask

    task automatic test_collections();
        send_item(OP_LOCAL, TAG_USAGE, 3'd1, 32'h02);
        send_item(OP_MAIN, TAG_COLL, 3'd1, 32'h01);
        send_item(OP_LOCAL, TAG_UMIN, 3'd1, 32'h07);
        send_item(OP_LOCAL, TAG_USAGE, 3'd1, 32'h09);
        send_item(OP_MAIN, TAG_COLL, 3'd4, 32'h1234_56FF);
        send_item(OP_LOCAL, TAG_UMIN, 3'd2, 32'h0101);
        send_item(OP_MAIN, TAG_COLL, 3'd0, 32'hFFFF_FFFF);
        send_item(OP_MAIN, TAG_COLL, 3'd1, 32'h80);
        send_item(OP_MAIN, TAG_END_COLL, 3'd0, 32'h0);
    endtask

    task automatic test_stack();
        send_item(OP_GLOBAL, TAG_POP, 3'd0, 32'h0);
        for (int i = 0; i <= StackDepth; i++) begin
            send_item(OP_GLOBAL, TAG_PUSH, 3'd0, 32'h0);
            send_item(OP_GLOBAL, TAG_SIZE, 3'd1, 32'(i + 1));
        end
        send_item(OP_GLOBAL, TAG_COUNT, 3'd1, 32'h02);
        send_item(OP_MAIN, TAG_INPUT, 3'd0, 32'h0);
        for (int i = 0; i <= StackDepth; i++) begin
            send_item(OP_GLOBAL, TAG_POP, 3'd0, 32'h0);
            send_item(OP_MAIN, TAG_OUTPUT, 3'd0, 32'h0);
        end
    endtask

    task automatic test_usage_list_and_runs();
        send_item(OP_GLOBAL, TAG_SIZE, 3'd1, 32'h01);
        send_item(OP_GLOBAL, TAG_COUNT, 3'd1, 32'h05);
        for (int i = 0; i <= MaxUsages; i++) begin
            send_item(OP_LOCAL, TAG_USAGE, 3'd1, 32'(i + 1));
        end
        send_item(OP_MAIN, TAG_INPUT, 3'd0, 32'h0);
        send_item(OP_GLOBAL, TAG_COUNT, 3'd1, 32'(MaxRun));
        send_item(OP_MAIN, TAG_FEATURE, 3'd0, 32'h0);
        send_item(OP_GLOBAL, TAG_COUNT, 3'd2, 32'(MaxRun + 6));
        send_item(OP_GLOBAL, TAG_SIZE, 3'd2, 32'h0FFF);
        send_item(OP_MAIN, TAG_INPUT, 3'd0, 32'h0);
        send_item(OP_LOCAL, TAG_UMIN, 3'd4, 32'hFFFF_FFF0);
        send_item(OP_MAIN, TAG_OUTPUT, 3'd0, 32'h0);
        wait_drained();
    endtask

    task automatic random_item();
        logic [1:0]  op;
        logic [3:0]  tag;
        logic [2:0]  ds;
        logic [31:0] data;
        int          pick;
        pick = $urandom_range(99);
        ds = 3'($urandom_range(7));
        data = $urandom;
        if (pick < 10) begin
            op = 2'($urandom_range(3));
            tag = 4'($urandom_range(15));
            if (op == OP_GLOBAL && tag == TAG_COUNT) data[15:6] = '0;
        end else if (pick < 35) begin
            op = OP_LOCAL;
            tag = ($urandom_range(3) == 0) ? TAG_UMIN : TAG_USAGE;
            if ($urandom_range(5) == 0) tag = TAG_UMAX;
        end else if (pick < 65) begin
            op = OP_GLOBAL;
            case ($urandom_range(6))
                0: tag = TAG_PAGE;
                1: tag = TAG_SIZE;
                2: tag = TAG_ID;
                3: tag = TAG_PUSH;
                4: tag = TAG_POP;
                default: tag = TAG_COUNT;
            endcase
            if (tag == TAG_COUNT) begin
                ds = 3'($urandom_range(1, 7));
                data[15:0] = ($urandom_range(9) == 0) ? 16'($urandom_range(80))
                                                       : 16'($urandom_range(6));
            end
        end else begin
            op = OP_MAIN;
            case ($urandom_range(5))
                0: tag = TAG_OUTPUT;
                1: tag = TAG_FEATURE;
                2: tag = TAG_COLL;
                3: tag = TAG_END_COLL;
                default: tag = TAG_INPUT;
            endcase
        end
        send_item(op, tag, ds, data);
    endtask

    task automatic test_random();
        int src[5] = '{0, 81, 0, 32, 0};
        int snk[5] = '{0, 0, 81, 32, 0};
        for (int p = 0; p < 5; p++) begin
            sender_idle_pct = src[p];
            receiver_stall_pct = snk[p];
            repeat (28) random_item();
            wait_drained();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_opcode    = '0;
        s_item_tag  = '0;
        s_data_size = '0;
        s_item_data = '0;
        m_ready     = 1'b0;
        err_count   = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i <= StackDepth; i++) gstack[i] = '0;
        level = 0;
        usage_cnt = 0;
        range_on = 1'b0;
        range_low = '0;
        range_high = '0;
        cursor = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_globals_and_fields();
        test_collections();
        test_stack();
        test_usage_list_and_runs();
        test_random();

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);
        if (err_count == 0 && event_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
